[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shared same-cycle and next-cycle implication checks for rtl assertions
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/mbe_pkg.sv]
// ----------------------------------------------------------------------------
// mbe_pkg
// types, constants and helpers of the mandelbrot escape-time unit
// ----------------------------------------------------------------------------
`default_nettype none

package mbe_pkg;

   localparam int unsigned FRAC_BITS = 28;
   localparam int unsigned COORD_W   = 32;
   localparam int unsigned PROD_W    = 2 * COORD_W;
   localparam int unsigned COUNT_W   = 16;

   localparam logic [COUNT_W-1:0] LIMIT_RESET = 16'd5000;

   // |z|^2 <= 4 in the square format; everything fits once 4 is out of range
   localparam logic [PROD_W-1:0] RADIUS_SQ =
      (2 * FRAC_BITS + 2 >= PROD_W) ? {PROD_W{1'b1}}
                                    : (64'd1 << (2 * FRAC_BITS + 2));

   typedef logic signed [COORD_W-1:0] operand_type;
   typedef logic signed [PROD_W-1:0]  product_type;
   typedef logic [COUNT_W-1:0]        count_type;

   typedef struct packed {
      logic        ovf;
      operand_type val;
   } sat_type;

   // clamp a wide signed value to the coordinate range
   function automatic sat_type sat_coord(input product_type v);
      sat_type r;
      r.ovf = !((&v[PROD_W-1:COORD_W-1]) || !(|v[PROD_W-1:COORD_W-1]));
      if (r.ovf) begin
         r.val = v[PROD_W-1] ? {1'b1, {(COORD_W-1){1'b0}}}
                             : {1'b0, {(COORD_W-1){1'b1}}};
      end else begin
         r.val = v[COORD_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/mbe_mul.sv]
// ----------------------------------------------------------------------------
// mbe_mul
// shared signed 32x32 multiplier with registered full-width product
// ----------------------------------------------------------------------------
`default_nettype none

module mbe_mul (
   input  wire                   clock,
   input  mbe_pkg::operand_type  op_a,
   input  mbe_pkg::operand_type  op_b,
   output mbe_pkg::product_type  prod
);
   import mbe_pkg::*;

   product_type prod_ff;
   product_type prod_in;

   assign prod_in = product_type'(op_a) * product_type'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

[hw/rtl/mandelbrot_escape_time.sv]
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// escape-time iteration of z = z*z + c in fixed point on one shared multiplier
// ----------------------------------------------------------------------------
// each iteration steps through zr*zr, zi*zi, zr*zi on the one 32x32
// multiplier, then an update step; the result strobe is registered out of
// the final update step, the number of update steps per point running from
// 1 up to the iteration limit, and the next request can be taken while the
// strobe is high, so points are handled one at a time.
// the receiver cannot stall. reset clears the sequencer and sets the limit to 5000.
`default_nettype none

module mandelbrot_escape_time (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    start,
   output logic                   busy,
   input  mbe_pkg::operand_type   req_c_real,
   input  mbe_pkg::operand_type   req_c_imag,
   output logic                   rsp_valid,
   output logic                   rsp_inside_res,
   output mbe_pkg::count_type     rsp_escape_count,
   input  wire                    csr_valid,
   output logic                   csr_ready,
   input  mbe_pkg::count_type     csr_wdata
);
   import mbe_pkg::*;

   `include "assert_macros.svh"

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_MUL_RR = 3'd1;
   localparam logic [2:0] ST_MUL_II = 3'd2;
   localparam logic [2:0] ST_MUL_RI = 3'd3;
   localparam logic [2:0] ST_UPDATE = 3'd4;

   logic [2:0]  state_ff, state_in;
   count_type   limit_ff, limit_in;
   count_type   count_ff, count_in;
   operand_type zr_ff, zr_in, zi_ff, zi_in;
   operand_type cr_ff, cr_in, ci_ff, ci_in;
   product_type sqr_ff, sqr_in;
   logic [PROD_W-1:0] mag_ff, mag_in;
   product_type diff_ff, diff_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        inside_ff, inside_in;
   count_type   res_count_ff, res_count_in;

   operand_type op_a, op_b;
   product_type prod;
   product_type re_wide, im_wide;
   sat_type     re_sat, im_sat;
   count_type   count_inc;
   logic        accept, in_radius, keep_going;

   mbe_mul u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   assign op_a = (state_ff == ST_MUL_II) ? zi_ff : zr_ff;
   assign op_b = (state_ff == ST_MUL_RR) ? zr_ff : zi_ff;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   // update step arithmetic: floor shifts are arithmetic right shifts
   assign in_radius  = (mag_ff <= RADIUS_SQ);
   assign keep_going = in_radius && (count_ff < limit_ff);
   assign count_inc  = count_ff + count_type'(1);
   assign re_wide    = (diff_ff >>> FRAC_BITS) + product_type'(cr_ff);
   assign im_wide    = (prod >>> (FRAC_BITS - 1)) + product_type'(ci_ff);
   assign re_sat     = sat_coord(re_wide);
   assign im_sat     = sat_coord(im_wide);

   always_comb begin
      state_in     = state_ff;
      limit_in     = limit_ff;
      count_in     = count_ff;
      zr_in        = zr_ff;
      zi_in        = zi_ff;
      cr_in        = cr_ff;
      ci_in        = ci_ff;
      sqr_in       = sqr_ff;
      mag_in       = mag_ff;
      diff_in      = diff_ff;
      rsp_valid_in = 1'b0;
      inside_in    = inside_ff;
      res_count_in = res_count_ff;

      if (csr_valid && csr_ready) begin
         limit_in = csr_wdata;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               zr_in    = req_c_real;
               zi_in    = req_c_imag;
               cr_in    = req_c_real;
               ci_in    = req_c_imag;
               count_in = count_type'(1);
               state_in = ST_MUL_RR;
            end
         end
         ST_MUL_RR: begin
            state_in = ST_MUL_II;
         end
         ST_MUL_II: begin
            sqr_in   = prod;
            state_in = ST_MUL_RI;
         end
         ST_MUL_RI: begin
            // both squares are non-negative, the unsigned sum fits in 64 bits
            mag_in   = sqr_ff + prod;
            diff_in  = sqr_ff - prod;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (!keep_going) begin
               rsp_valid_in = 1'b1;
               inside_in    = in_radius;
               res_count_in = count_ff;
               state_in     = ST_IDLE;
            end else if (re_sat.ovf || im_sat.ovf) begin
               rsp_valid_in = 1'b1;
               inside_in    = 1'b0;
               res_count_in = count_inc;
               state_in     = ST_IDLE;
            end else begin
               zr_in    = re_sat.val;
               zi_in    = im_sat.val;
               count_in = count_inc;
               state_in = ST_MUL_RR;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         limit_ff     <= LIMIT_RESET;
         count_ff     <= count_type'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      zr_ff        <= zr_in;
      zi_ff        <= zi_in;
      cr_ff        <= cr_in;
      ci_ff        <= ci_in;
      sqr_ff       <= sqr_in;
      mag_ff       <= mag_in;
      diff_ff      <= diff_in;
      inside_ff    <= inside_in;
      res_count_ff <= res_count_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_inside_res   = inside_ff;
   assign rsp_escape_count = res_count_ff;

   `ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy, "request accepted but not busy")
   `ASSERT_IMPLIES(a_rsp_idle, clock, reset, rsp_valid, !busy, "result strobe while busy")
   `ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid, "result strobe held twice")
   `ASSERT_IMPLIES(a_count_nonzero, clock, reset, busy, count_ff != count_type'(0),
      "iteration count wrapped to zero")

endmodule

`default_nettype wire
